### sv/hcs_pkg.sv
// hcs_pkg: shared types and constants of the header comment stripper
`default_nettype none
package hcs_pkg;

   localparam int HCS_DEPTH_MAX = 31;
   localparam int HCS_QDEPTH    = 2;
   localparam int HCS_QAW       = 1;

   localparam logic [15:0] HCS_CAP_RESET = 16'd256;
   localparam logic [15:0] HCS_COUNT_MAX = 16'hFFFF;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [17:0] RESERVE_BYTE  = 18'd3;
   localparam logic [17:0] RESERVE_OPEN  = 18'd4;

   typedef enum logic {
      CSR_ENABLE   = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_idx_type;

   typedef enum logic {
      SEL_CLEAN   = 1'b0,
      SEL_COMMENT = 1'b1
   } sel_type;

   typedef struct packed {
      logic       sel;
      logic [7:0] data;
   } ent_type;

   typedef struct packed {
      logic              is_end;
      logic              comment_end;
      logic [1:0]        n_ent;
      ent_type [2:0]     ent;
   } job_type;

endpackage
`default_nettype wire

### sv/header_comment_stripper.sv
// header_comment_stripper: top level of the mail header comment stripper
//
// Header bytes arrive on the req_ channel, one item per accepted byte; a
// byte of zero ends the string and returns all parse state to zero. Result
// items leave on the rsp_ channel: stream_sel picks the cleaned or comment
// stream, end_mark flags a terminator, last flags the final result of a byte.
// The csr_ port writes comments_enabled (index 0) and comment_capacity
// (index 1); write it only while the block is idle.
// With the block empty, the first result of a byte passes through the job
// queue and the output register before it is on rsp_. The back end emits
// one result per cycle while rsp_stall is low; a byte has 0 to 3 results
// for ordinary bytes, saved depth plus 2 for the end byte (1 with the comment
// stream off). The front end takes a byte every cycle while its two-entry
// job queue has room.
// Reset (synchronous, active high) restores the registers to enabled and
// capacity 256, clears parse state and empties queue and output register.
// While rsp_stall is high the output register holds its item; the queue
// then fills and req_stall rises.
`default_nettype none
module header_comment_stripper #(
   parameter int DEPTH_MAX = hcs_pkg::HCS_DEPTH_MAX
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_char_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_stream_sel,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_end_mark,
   output logic              rsp_last,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);
   import hcs_pkg::*;

   localparam int DW = $clog2(DEPTH_MAX + 1);

   logic             push;
   job_type          push_job;
   logic [DW-1:0]    push_close;
   logic             q_full;
   logic             pop;
   logic             head_valid;
   job_type          head_job;
   logic [DW-1:0]    head_close;

   hcs_front #(
      .DEPTH_MAX (DEPTH_MAX),
      .DW        (DW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_byte (req_char_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job),
      .push_close    (push_close)
   );

   hcs_queue #(
      .DW (DW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_close (push_close),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_close (head_close)
   );

   hcs_back #(
      .DEPTH_MAX (DEPTH_MAX),
      .DW        (DW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .head_close     (head_close),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_stream_sel (rsp_stream_sel),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_mark   (rsp_end_mark),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

### sv/hcs_front.sv
// hcs_front: item intake, csr registers, parse state and job building
`default_nettype none
module hcs_front #(
   parameter int DEPTH_MAX = hcs_pkg::HCS_DEPTH_MAX,
   parameter int DW        = $clog2(DEPTH_MAX + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_char_byte,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [15:0]           csr_wdata,
   input  wire logic                  q_full,
   output logic                       push,
   output hcs_pkg::job_type           push_job,
   output logic [DW-1:0]              push_close
);
   import hcs_pkg::*;

   localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);

   logic           enable_ff, enable_in;
   logic [15:0]    cap_ff, cap_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [DW-1:0]  saved_ff, saved_in;
   logic           quote_ff, quote_in;
   logic           esc_ff, esc_in;
   logic [15:0]    count_ff, count_in;

   logic           accept;
   logic [17:0]    used;
   logic           room3, room4;
   logic [1:0]     inc;
   logic [16:0]    count_sum;
   logic           clear;
   logic [DW-1:0]  nd;
   logic [7:0]     b;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_char_byte;
   assign used      = {2'b00, count_ff} + 18'(saved_ff);
   assign room3     = enable_ff && ((used + RESERVE_BYTE) < {2'b00, cap_ff});
   assign room4     = enable_ff && ((used + RESERVE_OPEN) < {2'b00, cap_ff});
   assign count_sum = {1'b0, count_ff} + 17'(inc);

   always_comb begin
      enable_in  = enable_ff;
      cap_in     = cap_ff;
      depth_in   = depth_ff;
      saved_in   = saved_ff;
      quote_in   = quote_ff;
      esc_in     = esc_ff;
      inc        = 2'd0;
      clear      = 1'b0;
      push       = 1'b0;
      push_job   = '0;
      push_close = '0;
      nd         = depth_ff;

      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_ENABLE:   enable_in = csr_wdata[0];
            CSR_CAPACITY: cap_in    = csr_wdata;
            default:      cap_in    = cap_ff;
         endcase
      end

      if (accept) begin
         if (b == CH_NUL) begin
            push                 = 1'b1;
            push_job.is_end      = 1'b1;
            push_job.comment_end = enable_ff;
            push_close           = enable_ff ? saved_ff : '0;
            clear                = 1'b1;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            if (depth_ff != '0) begin
               if (room3) begin
                  push           = 1'b1;
                  push_job.n_ent = 2'd2;
                  push_job.ent[0] = '{sel: SEL_COMMENT, data: CH_BSL};
                  push_job.ent[1] = '{sel: SEL_COMMENT, data: b};
                  inc            = 2'd2;
               end
            end else begin
               push            = 1'b1;
               push_job.n_ent  = 2'd2;
               push_job.ent[0] = '{sel: SEL_CLEAN, data: CH_BSL};
               push_job.ent[1] = '{sel: SEL_CLEAN, data: b};
            end
         end else if (b == CH_BSL && (quote_ff || depth_ff != '0)) begin
            esc_in = 1'b1;
         end else if (depth_ff != '0) begin
            if (b == CH_RPAR) begin
               nd = depth_ff - DW'(1);
            end else if (b == CH_LPAR && depth_ff < DMAX) begin
               nd = depth_ff + DW'(1);
            end
            depth_in = nd;
            if (room3) begin
               push            = 1'b1;
               push_job.n_ent  = 2'd1;
               push_job.ent[0] = '{sel: SEL_COMMENT, data: b};
               inc             = 2'd1;
               saved_in        = nd;
            end
         end else if (b == CH_QUOTE) begin
            quote_in        = !quote_ff;
            push            = 1'b1;
            push_job.n_ent  = 2'd1;
            push_job.ent[0] = '{sel: SEL_CLEAN, data: b};
         end else if (!quote_ff && b == CH_LPAR) begin
            nd       = DW'(1);
            depth_in = nd;
            push     = 1'b1;
            if (room4) begin
               saved_in = nd;
               if (count_ff != '0) begin
                  push_job.n_ent  = 2'd3;
                  push_job.ent[0] = '{sel: SEL_COMMENT, data: CH_SPACE};
                  push_job.ent[1] = '{sel: SEL_COMMENT, data: CH_LPAR};
                  push_job.ent[2] = '{sel: SEL_CLEAN, data: CH_SPACE};
                  inc             = 2'd2;
               end else begin
                  push_job.n_ent  = 2'd2;
                  push_job.ent[0] = '{sel: SEL_COMMENT, data: CH_LPAR};
                  push_job.ent[1] = '{sel: SEL_CLEAN, data: CH_SPACE};
                  inc             = 2'd1;
               end
            end else begin
               push_job.n_ent  = 2'd1;
               push_job.ent[0] = '{sel: SEL_CLEAN, data: CH_SPACE};
            end
         end else if (quote_ff || b != CH_RPAR) begin
            push            = 1'b1;
            push_job.n_ent  = 2'd1;
            push_job.ent[0] = '{sel: SEL_CLEAN, data: b};
         end
      end

      count_in = count_sum[16] ? HCS_COUNT_MAX : count_sum[15:0];
      if (clear) begin
         depth_in = '0;
         saved_in = '0;
         quote_in = 1'b0;
         esc_in   = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         cap_ff    <= HCS_CAP_RESET;
         depth_ff  <= '0;
         saved_ff  <= '0;
         quote_ff  <= 1'b0;
         esc_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         cap_ff    <= cap_in;
         depth_ff  <= depth_in;
         saved_ff  <= saved_in;
         quote_ff  <= quote_in;
         esc_ff    <= esc_in;
         count_ff  <= count_in;
      end
   end

   a_esc_context: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (quote_ff || depth_ff != '0))
      else $error("escape pending outside quote and comment");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DMAX && saved_ff <= DMAX)
      else $error("nesting depth beyond bound");

endmodule
`default_nettype wire

### sv/hcs_queue.sv
// hcs_queue: short job queue between front and back
`default_nettype none
module hcs_queue #(
   parameter int DW = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hcs_pkg::job_type  push_job,
   input  wire logic [DW-1:0]     push_close,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output hcs_pkg::job_type       head_job,
   output logic [DW-1:0]          head_close
);
   import hcs_pkg::*;

   localparam int CW = $clog2(HCS_QDEPTH + 1);

   job_type                   job_ff [HCS_QDEPTH];
   logic [DW-1:0]             close_ff [HCS_QDEPTH];
   logic [HCS_QAW-1:0]        wr_ff, wr_in;
   logic [HCS_QAW-1:0]        rd_ff, rd_in;
   logic [CW-1:0]             cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(HCS_QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = job_ff[rd_ff];
   assign head_close = close_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + HCS_QAW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + HCS_QAW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ff]   <= push_job;
         close_ff[wr_ff] <= push_close;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

### sv/hcs_back.sv
// hcs_back: expands queued jobs into result items through the output register
`default_nettype none
module hcs_back #(
   parameter int DEPTH_MAX = hcs_pkg::HCS_DEPTH_MAX,
   parameter int DW        = $clog2(DEPTH_MAX + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire hcs_pkg::job_type  head_job,
   input  wire logic [DW-1:0]     head_close,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_stream_sel,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_end_mark,
   output logic                   rsp_last
);
   import hcs_pkg::*;

   localparam int CW = $clog2(DEPTH_MAX + 3);

   logic [CW-1:0]  pos_ff, pos_in;
   logic           valid_ff, valid_in;
   logic           sel_ff, sel_in;
   logic [7:0]     byte_ff, byte_in;
   logic           end_ff, end_in;
   logic           last_ff, last_in;

   logic           advance;
   logic [CW-1:0]  total;
   logic [CW-1:0]  close_w;
   logic           is_last;

   assign advance = !valid_ff || !rsp_stall;
   assign close_w = CW'(head_close);
   assign total   = head_job.is_end
                    ? close_w + CW'(1) + CW'(head_job.comment_end)
                    : CW'(head_job.n_ent);
   assign is_last = (pos_ff == total - CW'(1));
   assign pop     = advance && head_valid && is_last;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            last_in = is_last;
            pos_in  = is_last ? '0 : pos_ff + CW'(1);
            if (head_job.is_end) begin
               if (pos_ff < close_w) begin
                  sel_in  = SEL_COMMENT;
                  byte_in = CH_RPAR;
                  end_in  = 1'b0;
               end else if (head_job.comment_end && pos_ff == close_w) begin
                  sel_in  = SEL_COMMENT;
                  byte_in = CH_NUL;
                  end_in  = 1'b1;
               end else begin
                  sel_in  = SEL_CLEAN;
                  byte_in = CH_NUL;
                  end_in  = 1'b1;
               end
            end else begin
               end_in = 1'b0;
               case (pos_ff[1:0])
                  2'd0:    {sel_in, byte_in} = head_job.ent[0];
                  2'd1:    {sel_in, byte_in} = head_job.ent[1];
                  default: {sel_in, byte_in} = head_job.ent[2];
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_stream_sel = sel_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_end_mark   = end_ff;
   assign rsp_last       = last_ff;

   a_pos_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> pos_ff < total)
      else $error("result position beyond job length");

endmodule
`default_nettype wire
